@@ rtl/core/tbc_pkg.sv @@
// Shared types, constants and the restoring division step for the tick conversion block.
// No dependencies.
`timescale 1ns / 1ps
package tbc_pkg;

  localparam int DIV_STEPS  = 64;
  localparam int FRAC_STEPS = 10;

  localparam logic [9:0]  MS_PER_S = 10'd1000;
  localparam logic [22:0] MS_Q_MAX = 23'd4294967;
  localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

  localparam logic [2:0] MODE_TO_MS   = 3'd0;
  localparam logic [2:0] MODE_TO_S    = 3'd1;
  localparam logic [2:0] MODE_MS_PART = 3'd2;
  localparam logic [2:0] MODE_MS_TICK = 3'd3;
  localparam logic [2:0] MODE_S_TICK  = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic       rate_zero;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        q;
  } step_t;

  function automatic step_t div_step(input logic [31:0] rem, input logic b,
                                     input logic [31:0] d);
    logic [32:0] t;
    step_t       s;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      s.rem = 32'(t - {1'b0, d});
      s.q   = 1'b1;
    end else begin
      s.rem = t[31:0];
      s.q   = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/core/timebase_tick_conversion.sv @@
// Top level of the timebase tick conversion block: rate register, pipeline and stall control.
// Depends on tbc_pkg, tbc_front, tbc_divider, tbc_frac and tbc_back.
//
//   channel | ports                                   | direction
//   in      | in_valid in_ready in_mode in_ticks in_amount | item in
//   out     | out_valid out_ready out_result out_saturated | item out
//   cfg     | cfg_we cfg_wdata                        | rate write
//
// One item is accepted per cycle while the output is not stalled; each item passes through 79
// register stages before its result is offered. The depth is set by two front stages, the
// 64 quotient stages of the tick divider, the product stage and 10 stages of the fraction
// divider, and two back stages.
// Reset clears every valid bit and the rate register.
// When the output register holds an item that is not taken, the whole pipeline holds.
`timescale 1ns / 1ps
module timebase_tick_conversion import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_ticks,
  input  logic [31:0] in_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result,
  output logic        out_saturated
);

  logic [31:0] tick_rate_r;
  logic        en;

  logic        fr_v;
  logic [63:0] fr_dividend;
  logic [31:0] fr_divisor;
  side_t       fr_side;
  logic        dv_v;
  logic [63:0] dv_quot;
  logic [31:0] dv_rem;
  logic [31:0] dv_divisor;
  side_t       dv_side;
  logic        fc_v;
  logic [63:0] fc_quot;
  logic [9:0]  fc_frac;
  side_t       fc_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= 32'd0;
    end else if (cfg_we) begin
      tick_rate_r <= cfg_wdata;
    end
  end

  tbc_front u_front (
    .clk, .rst_n, .en,
    .tick_rate    (tick_rate_r),
    .in_v         (in_valid && in_ready),
    .in_mode, .in_ticks, .in_amount,
    .out_v        (fr_v),
    .out_dividend (fr_dividend),
    .out_divisor  (fr_divisor),
    .out_side     (fr_side)
  );

  tbc_divider u_div (
    .clk, .rst_n, .en,
    .in_v        (fr_v),
    .in_dividend (fr_dividend),
    .in_divisor  (fr_divisor),
    .in_side     (fr_side),
    .out_v       (dv_v),
    .out_quot    (dv_quot),
    .out_rem     (dv_rem),
    .out_divisor (dv_divisor),
    .out_side    (dv_side)
  );

  tbc_frac u_frac (
    .clk, .rst_n, .en,
    .in_v       (dv_v),
    .in_quot    (dv_quot),
    .in_rem     (dv_rem),
    .in_divisor (dv_divisor),
    .in_side    (dv_side),
    .out_v      (fc_v),
    .out_quot   (fc_quot),
    .out_frac   (fc_frac),
    .out_side   (fc_side)
  );

  tbc_back u_back (
    .clk, .rst_n, .en,
    .in_v          (fc_v),
    .in_quot       (fc_quot),
    .in_frac       (fc_frac),
    .in_side       (fc_side),
    .out_v         (out_valid),
    .out_result    (out_result),
    .out_saturated (out_saturated)
  );

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_result == 64'(SAT32))
    else $error("saturated item without clamped value");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

@@ rtl/core/tbc_front.sv @@
// Input register and operand stage: forms the product and selects dividend and divisor.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
module tbc_front import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [31:0] tick_rate,
  input  logic        in_v,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_ticks,
  input  logic [31:0] in_amount,
  output logic        out_v,
  output logic [63:0] out_dividend,
  output logic [31:0] out_divisor,
  output side_t       out_side
);

  logic        f1_v_r;
  logic [2:0]  f1_mode_r;
  logic [63:0] f1_ticks_r;
  logic [31:0] f1_amount_r;
  logic        f2_v_r;
  logic [63:0] dividend_r, dividend_nxt;
  logic [31:0] divisor_r, divisor_nxt;
  side_t       side_r, side_nxt;
  logic [63:0] prod;

  assign prod = 64'(tick_rate) * 64'(f1_amount_r);

  always_comb begin
    side_nxt.mode      = f1_mode_r;
    side_nxt.rate_zero = (tick_rate == 32'd0);
    dividend_nxt       = f1_ticks_r;
    divisor_nxt        = tick_rate;
    if (f1_mode_r == MODE_MS_TICK) begin
      dividend_nxt = prod;
      divisor_nxt  = 32'(MS_PER_S);
    end else if (f1_mode_r == MODE_S_TICK) begin
      dividend_nxt = prod;
      divisor_nxt  = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_v;
      f2_v_r <= f1_v_r;
    end
    if (en) begin
      f1_mode_r   <= in_mode;
      f1_ticks_r  <= in_ticks;
      f1_amount_r <= in_amount;
      dividend_r  <= dividend_nxt;
      divisor_r   <= divisor_nxt;
      side_r      <= side_nxt;
    end
  end

  assign out_v        = f2_v_r;
  assign out_dividend = dividend_r;
  assign out_divisor  = divisor_r;
  assign out_side     = side_r;

endmodule

@@ rtl/core/tbc_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, 64 by 32 bits.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
module tbc_divider import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] in_dividend,
  input  logic [31:0] in_divisor,
  input  side_t       in_side,
  output logic        out_v,
  output logic [63:0] out_quot,
  output logic [31:0] out_rem,
  output logic [31:0] out_divisor,
  output side_t       out_side
);

  logic        v_r   [0:DIV_STEPS-1];
  logic [31:0] rem_r [0:DIV_STEPS-1];
  logic [63:0] dq_r  [0:DIV_STEPS-1];
  logic [31:0] d_r   [0:DIV_STEPS-1];
  side_t       s_r   [0:DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    logic        v_i;
    logic [31:0] rem_i;
    logic [63:0] dq_i;
    logic [31:0] d_i;
    side_t       s_i;
    step_t       st;
    if (k == 0) begin : g_first
      assign v_i   = in_v;
      assign rem_i = 32'd0;
      assign dq_i  = in_dividend;
      assign d_i   = in_divisor;
      assign s_i   = in_side;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign dq_i  = dq_r[k-1];
      assign d_i   = d_r[k-1];
      assign s_i   = s_r[k-1];
    end
    assign st = div_step(rem_i, dq_i[63], d_i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
      if (en) begin
        rem_r[k] <= st.rem;
        dq_r[k]  <= {dq_i[62:0], st.q};
        d_r[k]   <= d_i;
        s_r[k]   <= s_i;
      end
    end
  end

  assign out_v       = v_r[DIV_STEPS-1];
  assign out_quot    = dq_r[DIV_STEPS-1];
  assign out_rem     = rem_r[DIV_STEPS-1];
  assign out_divisor = d_r[DIV_STEPS-1];
  assign out_side    = s_r[DIV_STEPS-1];

endmodule

@@ rtl/core/tbc_frac.sv @@
// Millisecond fraction: remainder times 1000, then a ten-stage restoring divide by the divisor.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
module tbc_frac import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] in_quot,
  input  logic [31:0] in_rem,
  input  logic [31:0] in_divisor,
  input  side_t       in_side,
  output logic        out_v,
  output logic [63:0] out_quot,
  output logic [9:0]  out_frac,
  output side_t       out_side
);

  logic        m_v_r;
  logic [41:0] m_prod_r;
  logic [63:0] m_q_r;
  logic [31:0] m_d_r;
  side_t       m_s_r;

  logic        v_r   [0:FRAC_STEPS-1];
  logic [31:0] rem_r [0:FRAC_STEPS-1];
  logic [9:0]  fq_r  [0:FRAC_STEPS-1];
  logic [63:0] q_r   [0:FRAC_STEPS-1];
  logic [31:0] d_r   [0:FRAC_STEPS-1];
  side_t       s_r   [0:FRAC_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_v;
    end
    if (en) begin
      m_prod_r <= 42'(in_rem) * 42'(MS_PER_S);
      m_q_r    <= in_quot;
      m_d_r    <= in_divisor;
      m_s_r    <= in_side;
    end
  end

  for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_st
    logic        v_i;
    logic [31:0] rem_i;
    logic [9:0]  fq_i;
    logic [63:0] q_i;
    logic [31:0] d_i;
    side_t       s_i;
    step_t       st;
    if (k == 0) begin : g_first
      assign v_i   = m_v_r;
      assign rem_i = m_prod_r[41:10];
      assign fq_i  = m_prod_r[9:0];
      assign q_i   = m_q_r;
      assign d_i   = m_d_r;
      assign s_i   = m_s_r;
    end else begin : g_next
      assign v_i   = v_r[k-1];
      assign rem_i = rem_r[k-1];
      assign fq_i  = fq_r[k-1];
      assign q_i   = q_r[k-1];
      assign d_i   = d_r[k-1];
      assign s_i   = s_r[k-1];
    end
    assign st = div_step(rem_i, fq_i[9], d_i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
      if (en) begin
        rem_r[k] <= st.rem;
        fq_r[k]  <= {fq_i[8:0], st.q};
        q_r[k]   <= q_i;
        d_r[k]   <= d_i;
        s_r[k]   <= s_i;
      end
    end
  end

  assign out_v    = v_r[FRAC_STEPS-1];
  assign out_quot = q_r[FRAC_STEPS-1];
  assign out_frac = fq_r[FRAC_STEPS-1];
  assign out_side = s_r[FRAC_STEPS-1];

endmodule

@@ rtl/core/tbc_back.sv @@
// Final stages: seconds to milliseconds scaling, saturation, mode selection and output register.
// Depends on tbc_pkg.
`timescale 1ns / 1ps
module tbc_back import tbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] in_quot,
  input  logic [9:0]  in_frac,
  input  side_t       in_side,
  output logic        out_v,
  output logic [63:0] out_result,
  output logic        out_saturated
);

  logic        b_v_r;
  logic        big_r;
  logic        qhi_r;
  logic [32:0] msp_r;
  logic [63:0] q_r;
  logic [9:0]  frac_r;
  side_t       s_r;
  logic        o_v_r;
  logic [63:0] res_r, res_nxt;
  logic        sat_r, sat_nxt;
  logic [33:0] sum;

  assign sum = 34'(msp_r) + 34'(frac_r);

  always_comb begin
    res_nxt = 64'd0;
    sat_nxt = 1'b0;
    unique case (s_r.mode)
      MODE_TO_MS: begin
        if (!s_r.rate_zero) begin
          if (big_r || sum > 34'(SAT32)) begin
            res_nxt = 64'(SAT32);
            sat_nxt = 1'b1;
          end else begin
            res_nxt = 64'(sum);
          end
        end
      end
      MODE_TO_S: begin
        if (!s_r.rate_zero) begin
          if (qhi_r) begin
            res_nxt = 64'(SAT32);
            sat_nxt = 1'b1;
          end else begin
            res_nxt = 64'(q_r[31:0]);
          end
        end
      end
      MODE_MS_PART: begin
        if (!s_r.rate_zero) begin
          res_nxt = 64'(frac_r);
        end
      end
      MODE_MS_TICK, MODE_S_TICK: begin
        res_nxt = q_r;
      end
      default: begin
        res_nxt = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= in_v;
      o_v_r <= b_v_r;
    end
    if (en) begin
      big_r  <= (|in_quot[63:23]) || (in_quot[22:0] > MS_Q_MAX);
      qhi_r  <= |in_quot[63:32];
      msp_r  <= 33'(in_quot[22:0]) * 33'(MS_PER_S);
      q_r    <= in_quot;
      frac_r <= in_frac;
      s_r    <= in_side;
      res_r  <= res_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_v         = o_v_r;
  assign out_result    = res_r;
  assign out_saturated = sat_r;

endmodule
